@@ rtl/dct_ii_block_transform_defines.svh @@
// =============================================================================
// dct_ii_block_transform_defines.svh
// Assertion macros shared by the DCT-II block transform RTL.
// =============================================================================
`ifndef DCT_II_BLOCK_TRANSFORM_DEFINES_SVH
`define DCT_II_BLOCK_TRANSFORM_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dct_pkg.sv @@
// =============================================================================
// dct_pkg
// Shared types, constants and elaboration-time ROM helpers for the DCT-II block.
// =============================================================================
package dct_pkg;

  localparam int unsigned BLOCK_LEN_DEF = 64;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned COEF_W        = 20;
  localparam int unsigned BIN_W         = 6;
  localparam int unsigned PROD_W        = 32;
  localparam int unsigned IN_TDATA_W    = 16;
  localparam int unsigned OUT_TDATA_W   = 32;

  localparam logic [COEF_W-1:0] COEF_MAX = 20'h7FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 20'h80000;

  localparam longint unsigned PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } dct_state_e;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;     // store incoming sample
    logic issue;     // one MAC step
    logic first;     // first step of a coefficient
    logic last;      // last step of a coefficient
    logic load_out;  // move rounded sum to output register
  } dct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic acc_done;  // sum of current coefficient complete
    logic out_free;  // output register can take a new coefficient
  } dct_sts_t;

  // cos(pi*m/(2n)) in signed Q30, m < 4n; step = PI_Q62 / (2n)
  function automatic longint cos_q30(int unsigned m, int unsigned n,
                                     longint unsigned step);
    logic            neg;
    int unsigned     mm;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    neg = 1'b0;
    mm  = m;
    if (mm > 2 * n) mm = 4 * n - mm;
    if (mm > n) begin
      neg = 1'b1;
      mm  = 2 * n - mm;
    end
    if (mm == n) return 64'sd0;
    x    = (step * 64'(mm) + 64'h8000_0000) >> 32;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = ONE_Q30;
    sum  = longint'(term);
    // Taylor series, thirteen terms; divisors are (2j-1)*2j
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd240; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd306; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd380; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd462; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd552; sum = sum + longint'(term);
    if (sum < 0) sum = 64'sd0;
    return neg ? -sum : sum;
  endfunction

  // integer square root, digit by digit
  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // nearest Q1.15 of sqrt(t) in Q30 with sign, saturated at +32767
  function automatic logic signed [SAMPLE_W-1:0] rom_q15(longint unsigned t, logic neg);
    longint unsigned r;
    r = (isqrt64(t) + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return neg ? SAMPLE_W'(64'd0 - r) : SAMPLE_W'(r);
  endfunction

endpackage

@@ rtl/dct_ii_block_transform.sv @@
// =============================================================================
// dct_ii_block_transform
// Orthonormal DCT-II over blocks of BLOCK_LEN signed Q1.15 audio samples.
// =============================================================================
// Samples arrive one request per cycle on the slave stream while the block
// fills its sample store. Once BLOCK_LEN samples are held, the input stalls
// and the block emits BLOCK_LEN coefficients u = 0 .. BLOCK_LEN-1 in order,
// each a signed Q4.15 value rounded to nearest (ties away from zero) and
// saturated to 20 bits, with tlast on the final bin. A single MAC unit
// computes every coefficient as a direct sum of sample times a Q1.15 scaled
// cosine from a ROM built at elaboration (a constant for bin 0): BLOCK_LEN
// MAC steps, then the MAC pipeline drains and the rounded sum moves to
// the output register once that register is free. A held coefficient
// sits in the output register, so the next block may start filling
// while the last coefficient still waits to be taken. No clearing
// pass follows reset.

module dct_ii_block_transform #(
  parameter int unsigned BLOCK_LEN = dct_pkg::BLOCK_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dct_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [15:0] sample
  // coefficient stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [19:0] coefficient,
                                                            // [25:20] bin_index,
                                                            // [31:26] zero
  output logic                              m_axis_tlast    // block_end
);

  localparam int unsigned IW = $clog2(BLOCK_LEN);

  dct_pkg::dct_cmd_t           cmd;
  dct_pkg::dct_sts_t           sts;
  logic [IW-1:0]               wr_addr;
  logic [IW-1:0]               rd_addr;
  logic [IW-1:0]               u_idx;
  logic [dct_pkg::COEF_W-1:0]  coef;
  logic [dct_pkg::BIN_W-1:0]   bin;

  // sequencer: fill, MAC steps per bin, drain, emit
  dct_ctrl #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .u_o        (u_idx)
  );

  // store, ROM, MAC and output register
  dct_dp #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .u_i         (u_idx),
    .sample_i    (s_axis_tdata[dct_pkg::SAMPLE_W-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .coef_o      (coef),
    .bin_o       (bin),
    .last_o      (m_axis_tlast)
  );

  // pack fields from the low bit up, zero fill to the byte
  assign m_axis_tdata = {
    (dct_pkg::OUT_TDATA_W - dct_pkg::COEF_W - dct_pkg::BIN_W)'(0), bin, coef
  };

endmodule

@@ rtl/dct_ctrl.sv @@
// =============================================================================
// dct_ctrl
// Sequencer: fills the sample store, then steps the MAC over every bin.
// =============================================================================
`include "dct_ii_block_transform_defines.svh"

module dct_ctrl #(
  parameter  int unsigned BLOCK_LEN = dct_pkg::BLOCK_LEN_DEF,
  localparam int unsigned IW        = $clog2(BLOCK_LEN)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dct_pkg::dct_sts_t sts_i,
  output dct_pkg::dct_cmd_t cmd_o,
  output logic [IW-1:0]    wr_addr_o,
  output logic [IW-1:0]    rd_addr_o,
  output logic [IW-1:0]    u_o
);

  localparam logic [IW-1:0] LAST = IW'(BLOCK_LEN - 1);

  dct_pkg::dct_state_e state_q, state_d;
  logic [IW-1:0] fill_q, fill_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] u_q, u_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dct_pkg::ST_FILL;
      fill_q  <= '0;
      i_q     <= '0;
      u_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      i_q     <= i_d;
      u_q     <= u_d;
    end
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    i_d     = i_q;
    u_d     = u_q;
    case (state_q)
      dct_pkg::ST_FILL: begin
        if (in_valid_i) begin
          if (fill_q == LAST) begin
            fill_d  = '0;
            i_d     = '0;
            u_d     = '0;
            state_d = dct_pkg::ST_RUN;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      dct_pkg::ST_RUN: begin
        if (i_q == LAST) begin
          i_d     = '0;
          state_d = dct_pkg::ST_DRAIN;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      dct_pkg::ST_DRAIN: begin
        if (sts_i.acc_done) state_d = dct_pkg::ST_EMIT;
      end
      dct_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          if (u_q == LAST) begin
            u_d     = '0;
            state_d = dct_pkg::ST_FILL;
          end else begin
            u_d     = u_q + 1'b1;
            state_d = dct_pkg::ST_RUN;
          end
        end
      end
      default: state_d = dct_pkg::ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      dct_pkg::ST_FILL: begin
        in_ready_o   = 1'b1;
        cmd_o.wr_en  = in_valid_i;
      end
      dct_pkg::ST_RUN: begin
        cmd_o.issue  = 1'b1;
        cmd_o.first  = (i_q == '0);
        cmd_o.last   = (i_q == LAST);
      end
      dct_pkg::ST_EMIT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: ;
    endcase
  end

  assign wr_addr_o = fill_q;
  assign rd_addr_o = i_q;
  assign u_o       = u_q;

  `DCT_ASSERT_IMPL(a_done_in_drain, sts_i.acc_done, state_q == dct_pkg::ST_DRAIN,
    "sum completed outside drain")
  `DCT_ASSERT_NEXT(a_run_to_drain, state_q == dct_pkg::ST_RUN && i_q == LAST,
    state_q == dct_pkg::ST_DRAIN, "last MAC step not followed by drain")

endmodule

@@ rtl/dct_dp.sv @@
// =============================================================================
// dct_dp
// Sample store, cosine ROM, MAC pipeline, rounding and output register.
// =============================================================================
`include "dct_ii_block_transform_defines.svh"

module dct_dp #(
  parameter  int unsigned BLOCK_LEN = dct_pkg::BLOCK_LEN_DEF,
  localparam int unsigned IW        = $clog2(BLOCK_LEN)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dct_pkg::dct_cmd_t                      cmd_i,
  output dct_pkg::dct_sts_t                      sts_o,
  input  logic [IW-1:0]                          wr_addr_i,
  input  logic [IW-1:0]                          rd_addr_i,
  input  logic [IW-1:0]                          u_i,
  input  logic signed [dct_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [dct_pkg::COEF_W-1:0]             coef_o,
  output logic [dct_pkg::BIN_W-1:0]              bin_o,
  output logic                                   last_o
);

  localparam int unsigned ROM_LEN = 4 * BLOCK_LEN;
  localparam int unsigned KW      = $clog2(ROM_LEN);
  localparam int unsigned ACC_W   = dct_pkg::PROD_W + IW;
  localparam int unsigned SW      = dct_pkg::SAMPLE_W;
  localparam longint unsigned STEP = dct_pkg::PI_Q62 / (2 * BLOCK_LEN);

  // ---- cosine ROM, built at elaboration ----
  logic signed [SW-1:0] rom_ac [ROM_LEN];

  for (genvar k = 0; k < ROM_LEN; k++) begin : g_rom
    localparam longint          CV  = dct_pkg::cos_q30(k, BLOCK_LEN, STEP);
    localparam longint unsigned MAG = (CV < 0) ? longint'(-CV) : CV;
    localparam longint unsigned TV  = (MAG * MAG * 2) / BLOCK_LEN;
    assign rom_ac[k] = dct_pkg::rom_q15(TV, CV < 0);
  end

  localparam longint unsigned DC_MAG = longint'(dct_pkg::cos_q30(0, BLOCK_LEN, STEP));
  localparam longint unsigned DC_T   = (DC_MAG * DC_MAG) / BLOCK_LEN;
  localparam logic signed [SW-1:0] W_DC = dct_pkg::rom_q15(DC_T, 1'b0);

  // ---- stage 1: store read, ROM read, index walk ----
  logic signed [SW-1:0] mem [BLOCK_LEN];
  logic signed [SW-1:0] rd_q;
  logic signed [SW-1:0] w_q;
  logic [KW-1:0]        k_q, k_d, k_cur;
  logic [KW:0]          k_sum;
  logic                 v1_q, f1_q, l1_q;

  assign k_cur = cmd_i.first ? KW'(u_i) : k_q;
  assign k_sum = {1'b0, k_cur} + (KW + 1)'({u_i, 1'b0});
  assign k_d   = (k_sum >= (KW + 1)'(ROM_LEN)) ? KW'(k_sum - (KW + 1)'(ROM_LEN))
                                                : KW'(k_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr_i] <= sample_i;
    if (cmd_i.issue) begin
      rd_q <= mem[rd_addr_i];
      w_q  <= (u_i == '0) ? W_DC : rom_ac[k_cur];
      k_q  <= k_d;
    end
  end

  // ---- stage 2: multiply; stage 3: accumulate ----
  logic signed [dct_pkg::PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic                              v2_q, f2_q, l2_q, done_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) prod_q <= rd_q * w_q;
    if (v2_q) acc_q  <= (f2_q ? '0 : acc_q) + ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      f1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      f2_q   <= 1'b0;
      l2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= cmd_i.issue;
      f1_q   <= cmd_i.first;
      l1_q   <= cmd_i.last;
      v2_q   <= v1_q;
      f2_q   <= f1_q;
      l2_q   <= l1_q;
      done_q <= v2_q & l2_q;
    end
  end

  // ---- round Q2.30 sum to Q4.15, ties away from zero, saturate ----
  logic                         neg;
  logic [ACC_W-1:0]             mag, rnd, q, qneg;
  logic [dct_pkg::COEF_W-1:0]   coef_d;

  always_comb begin
    neg  = acc_q[ACC_W-1];
    mag  = neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    rnd  = mag + ACC_W'(16384);
    q    = rnd >> 15;
    qneg = ACC_W'(0) - q;
    if (neg) begin
      coef_d = (q >= ACC_W'(524288)) ? dct_pkg::COEF_MIN : qneg[dct_pkg::COEF_W-1:0];
    end else begin
      coef_d = (q >= ACC_W'(524287)) ? dct_pkg::COEF_MAX : q[dct_pkg::COEF_W-1:0];
    end
  end

  // ---- output register ----
  logic                        ovalid_q;
  logic [dct_pkg::COEF_W-1:0]  coef_q;
  logic [dct_pkg::BIN_W-1:0]   bin_q;
  logic                        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      coef_q <= coef_d;
      bin_q  <= dct_pkg::BIN_W'(u_i);
      last_q <= (u_i == IW'(BLOCK_LEN - 1));
    end
  end

  assign sts_o.acc_done = done_q;
  assign sts_o.out_free = ~ovalid_q | out_ready_i;
  assign out_valid_o    = ovalid_q;
  assign coef_o         = coef_q;
  assign bin_o          = bin_q;
  assign last_o         = last_q;

  `DCT_ASSERT_IMPL(a_wr_idle, cmd_i.wr_en, !v1_q && !v2_q && !done_q,
    "sample stored while MAC pipeline busy")
  `DCT_ASSERT_IMPL(a_done_empty, done_q, !v1_q && !v2_q,
    "MAC step in flight after sum completed")

endmodule

@@ test/dct_ii_block_transform_checker.sv @@
// ----------------------------------------------------------------------------
// DCT-II block transform checker
// Watches both streams, predicts every coefficient of each completed block
// and compares the coefficient requests against the predictions in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_ii_block_transform_checker #(
  parameter int unsigned BLOCK_LEN = dct_pkg::BLOCK_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            sample_valid_i,
  input  logic                            sample_ready_i,
  input  logic [dct_pkg::IN_TDATA_W-1:0]  sample_data_i,   // [15:0] sample
  input  logic                            coef_valid_i,
  input  logic                            coef_ready_i,
  input  logic [dct_pkg::OUT_TDATA_W-1:0] coef_data_i,     // [19:0] coefficient,
                                                           // [25:20] bin_index
  input  logic                            coef_last_i,     // block_end
  output int                              mismatch_count_o,
  output int                              pending_o
);

  localparam int unsigned SAMPLE_W = dct_pkg::SAMPLE_W;
  localparam int unsigned COEF_W   = dct_pkg::COEF_W;
  localparam int unsigned BIN_W    = dct_pkg::BIN_W;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [BIN_W-1:0]         bin;
    logic                     block_end;
  } coef_req_t;

  localparam real PI         = 3.14159265358979323846;
  localparam int  MAX_REPORT = 10;

  int                         basis_weight [BLOCK_LEN][BLOCK_LEN];  // [u][i], Q1.15
  logic signed [SAMPLE_W-1:0] block_buf [BLOCK_LEN];
  int unsigned                fill_cnt;
  coef_req_t                  coef_queue [$];

  initial mismatch_count_o = 0;
  initial pending_o        = 0;
  initial fill_cnt         = 0;

  // nearest Q1.15 of the orthonormal cosine basis, clipped at +32767
  function automatic int scaled_cosine(int unsigned u, int unsigned i);
    int unsigned k;
    real         w;
    k = (u * (2 * i + 1)) % (4 * BLOCK_LEN);
    if (u == 0) begin
      w = $sqrt(1.0 / BLOCK_LEN);
    end else begin
      w = $sqrt(2.0 / BLOCK_LEN) * $cos(PI * k / (2.0 * BLOCK_LEN));
    end
    w = $floor(w * 32768.0 + 0.5);
    if (w > 32767.0) w = 32767.0;
    return int'(w);
  endfunction

  // Q2.30 sum to Q4.15, ties away from zero, saturated
  function automatic logic signed [COEF_W-1:0] round_q415(longint acc);
    longint mag;
    longint q;
    mag = (acc < 0) ? -acc : acc;
    q   = (mag + 64'sd16384) >>> 15;
    if (acc < 0) q = -q;
    if (q > 64'sd524287) q = 64'sd524287;
    if (q < -64'sd524288) q = -64'sd524288;
    return q[COEF_W-1:0];
  endfunction

  task automatic predict_block();
    longint    acc;
    coef_req_t req;
    for (int u = 0; u < BLOCK_LEN; u++) begin
      acc = 0;
      for (int i = 0; i < BLOCK_LEN; i++) begin
        acc += longint'(block_buf[i]) * longint'(basis_weight[u][i]);
      end
      req.coef      = round_q415(acc);
      req.bin       = BIN_W'(u);
      req.block_end = (u == BLOCK_LEN - 1);
      coef_queue    = {coef_queue, req};
    end
  endtask

  initial begin
    for (int u = 0; u < BLOCK_LEN; u++) begin
      for (int i = 0; i < BLOCK_LEN; i++) begin
        basis_weight[u][i] = scaled_cosine(u, i);
      end
    end
  end

  always @(posedge clk_i) begin : watch
    coef_req_t                want;
    logic signed [COEF_W-1:0] got_coef;
    logic [BIN_W-1:0]         got_bin;
    got_coef = coef_data_i[COEF_W-1:0];
    got_bin  = coef_data_i[COEF_W+BIN_W-1:COEF_W];
    if (rst_ni) begin
      if (sample_valid_i && sample_ready_i) begin
        block_buf[fill_cnt] = sample_data_i;
        fill_cnt++;
        if (fill_cnt == BLOCK_LEN) begin
          fill_cnt = 0;
          predict_block();
        end
      end
      if (coef_valid_i && coef_ready_i) begin
        if (coef_queue.size() == 0) begin
          if (mismatch_count_o < MAX_REPORT) begin
            $display("%0t: unexpected coefficient request: bin %0d coef %0d last %0b",
                     $realtime, got_bin, got_coef, coef_last_i);
          end
          mismatch_count_o++;
        end else begin
          want = coef_queue.pop_front();
          if (got_coef !== want.coef || got_bin !== want.bin ||
              coef_last_i !== want.block_end) begin
            if (mismatch_count_o < MAX_REPORT) begin
              $display("%0t: mismatch (exp/got) bin %0d/%0d coef %0d/%0d last %0b/%0b",
                       $realtime, want.bin, got_bin, want.coef, got_coef,
                       want.block_end, coef_last_i);
            end
            mismatch_count_o++;
          end
        end
      end
      pending_o = coef_queue.size();
    end
  end

endmodule

@@ test/tb_dct_ii_block_transform.sv @@
// ----------------------------------------------------------------------------
// DCT-II block transform testbench
// Feeds one directed block of extreme samples and two random blocks, with
// random idle bursts on both streams and one long sink hold-off that backs
// the block up; a checker alongside predicts and compares every coefficient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dct_ii_block_transform;

  localparam int unsigned SAMPLE_W    = dct_pkg::SAMPLE_W;
  localparam int unsigned IN_TDATA_W  = dct_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = dct_pkg::OUT_TDATA_W;

  localparam int unsigned BLOCK_LEN   = dct_pkg::BLOCK_LEN_DEF;
  localparam int          NUM_BLOCKS  = 3;           // one directed, two random
  localparam int          HOLD_CYCLES = 400;         // long sink hold-off
  localparam int          STUCK_LIMIT = 4000;        // cycles with no request at all
  localparam int          DRAIN_WAIT  = 2 * BLOCK_LEN + 16;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int mismatches;
  int coefs_pending;
  int stuck_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  dct_ii_block_transform #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  dct_ii_block_transform_checker #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .sample_valid_i   (s_axis_tvalid),
    .sample_ready_i   (s_axis_tready),
    .sample_data_i    (s_axis_tdata),
    .coef_valid_i     (m_axis_tvalid),
    .coef_ready_i     (m_axis_tready),
    .coef_data_i      (m_axis_tdata),
    .coef_last_i      (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .pending_o        (coefs_pending)
  );

  // Directed block: the field extremes and a few bit patterns up front,
  // then alternating full-scale values to drive the top bin hard.
  function automatic logic [SAMPLE_W-1:0] directed_sample(int idx);
    case (idx)
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return 16'h0000;
      3:       return 16'h0001;
      4:       return 16'hFFFF;
      5:       return 16'h5555;
      6:       return 16'hAAAA;
      7:       return 16'h4000;
      8:       return 16'hC000;
      9:       return 16'h00FF;
      10:      return 16'hFF00;
      default: return idx[0] ? SAMPLE_MIN : SAMPLE_MAX;
    endcase
  endfunction

  // random mix: full range mostly, with extremes and near-zero values
  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'($urandom_range(0, 127) - 64);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One sample request; inputs change on the falling edge, the handshake
  // is seen at the rising edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit may_idle);
    int gap;
    @(negedge clk_i);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sample source. Idle bursts come only in alternate stretches of 16
  // requests and never in the last block.
  initial begin : stimulus
    bit idle_ok;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      for (int i = 0; i < BLOCK_LEN; i++) begin
        idle_ok = (b < NUM_BLOCKS - 1) && ((i / 16) % 2 == 0);
        send_sample((b == 0) ? directed_sample(i) : random_sample(), idle_ok);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (coefs_pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (mismatches == 0 && coefs_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Coefficient sink. After the first block it holds off for a long
  // stretch so the next block fills and the sample input stalls. Stall
  // bursts come in alternate stretches of 16 coefficients and stop for
  // the last block.
  initial begin : sink
    int  taken;
    int  hold;
    bit  held_off;
    taken    = 0;
    hold     = 0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      @(negedge clk_i);
      if (!held_off && taken >= BLOCK_LEN) begin
        held_off = 1'b1;
        hold     = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (taken < (NUM_BLOCKS - 1) * BLOCK_LEN && (taken / 16) % 2 == 1 &&
                   $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles in which neither stream moves a request
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

endmodule
